/* design/stochastic_leaky_neuron_update_unit_assert.svh */
// Assertion macros shared by the checker of the neuron update unit.
// No dependencies; included by name from the checker file.
`ifndef STOCHASTIC_LEAKY_NEURON_UPDATE_UNIT_ASSERT_SVH
`define STOCHASTIC_LEAKY_NEURON_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLNU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLNU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/slnu_pkg.sv */
// Shared types and constants of the neuron update unit.
// No dependencies.
package slnu_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 10;
    localparam int POT_W     = 32;
    localparam int REFR_W    = 10;
    localparam int SMP_W     = 16;
    localparam int RECIP_W   = 17;
    localparam int STEPS_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR     = 3'd4;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_INIT   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;   // latch item, issue memory read
        logic load;     // take read data into the working potential
        logic mul1;     // leak product
        logic mul2;     // increment product
        logic acc;      // saturating accumulate, advance substep count
        logic finish;   // fire decision, write back, register result
        logic clr_wr;   // clearing pass write
    } t_dp_cmd;

    typedef struct packed {
        logic run_steps;  // update in range with a nonzero substep count
        logic last_step;
        logic clr_last;
    } t_dp_stat;

endpackage

/* design/stochastic_leaky_neuron_update_unit.sv */
// Update: after start the item is read, then each substep passes through the MUL1,
// MUL2 and ACC states of the leak/increment multiply-accumulate loop before DONE registers the result.
// Init, an index beyond the array or a zero substep count: READ goes straight to DONE.
// A new item is taken in the cycle its predecessor's result is shown.
// After reset busy stays high while the refractory counts clear.
// Results are a one-cycle strobe; the receiver cannot stall.
module stochastic_leaky_neuron_update_unit #(
    parameter int NEURONS   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [slnu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [slnu_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_command,
    input  logic [slnu_pkg::IDX_W-1:0]           i_neuron_index,
    input  logic signed [slnu_pkg::POT_W-1:0]    i_synaptic_current,
    input  logic [slnu_pkg::SMP_W-1:0]           i_threshold_sample,
    input  logic signed [slnu_pkg::POT_W-1:0]    i_initial_potential,
    output logic                                 o_valid,
    output logic [slnu_pkg::IDX_W-1:0]           o_neuron_echo,
    output logic                                 o_fired,
    output logic signed [slnu_pkg::POT_W-1:0]    o_potential,
    output logic [slnu_pkg::REFR_W-1:0]          o_refractory_left
);
    import slnu_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    slnu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    slnu_dp #(
        .NEURONS   (NEURONS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_command           (i_command),
        .i_neuron_index      (i_neuron_index),
        .i_synaptic_current  (i_synaptic_current),
        .i_threshold_sample  (i_threshold_sample),
        .i_initial_potential (i_initial_potential),
        .o_valid             (o_valid),
        .o_neuron_echo       (o_neuron_echo),
        .o_fired             (o_fired),
        .o_potential         (o_potential),
        .o_refractory_left   (o_refractory_left)
    );

endmodule

/* design/slnu_ctrl.sv */
// Controller state machine of the neuron update unit.
// Depends on slnu_pkg.
module slnu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  slnu_pkg::t_dp_stat  i_stat,
    output slnu_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import slnu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_stat.run_steps ? S_MUL1 : S_DONE;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC: begin
                n_state = i_stat.last_step ? S_DONE : S_MUL1;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_READ:  o_cmd.load   = 1'b1;
            S_MUL1:  o_cmd.mul1   = 1'b1;
            S_MUL2:  o_cmd.mul2   = 1'b1;
            S_ACC:   o_cmd.acc    = 1'b1;
            S_DONE:  o_cmd.finish = 1'b1;
            default: o_busy       = 1'b1;
        endcase
    end

endmodule

/* design/slnu_dp.sv */
// Datapath of the neuron update unit: configuration registers, neuron state
// memories, substep arithmetic and result register. Depends on slnu_pkg.
module slnu_dp #(
    parameter int NEURONS   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slnu_pkg::t_dp_cmd                    i_cmd,
    output slnu_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_cfg_we,
    input  logic [slnu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [slnu_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 i_command,
    input  logic [slnu_pkg::IDX_W-1:0]           i_neuron_index,
    input  logic signed [slnu_pkg::POT_W-1:0]    i_synaptic_current,
    input  logic [slnu_pkg::SMP_W-1:0]           i_threshold_sample,
    input  logic signed [slnu_pkg::POT_W-1:0]    i_initial_potential,
    output logic                                 o_valid,
    output logic [slnu_pkg::IDX_W-1:0]           o_neuron_echo,
    output logic                                 o_fired,
    output logic signed [slnu_pkg::POT_W-1:0]    o_potential,
    output logic [slnu_pkg::REFR_W-1:0]          o_refractory_left
);
    import slnu_pkg::*;

    localparam int AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int NW   = $clog2(NEURONS + 1);
    localparam int EW   = (NW > IDX_W) ? NW : IDX_W;
    localparam int DW   = POT_W + 1;                 // rest - x
    localparam int RW   = RECIP_W + 1;               // reciprocal as signed
    localparam int P1W  = DW + RW;
    localparam int LW   = P1W - FRAC_BITS;
    localparam int SW   = ((LW > POT_W) ? LW : POT_W) + 1;
    localparam int P2W  = SW + RW;
    localparam int IW   = P2W - FRAC_BITS;
    localparam int XW   = ((IW > POT_W) ? IW : POT_W) + 1;
    localparam int CW   = POT_W + SMP_W;             // fire compare width

    // configuration
    logic signed [POT_W-1:0]   r_rest;
    logic [RECIP_W-1:0]        r_inv_tau;
    logic [STEPS_W-1:0]        r_steps;
    logic [RECIP_W-1:0]        r_inv_step;
    logic [REFR_W-1:0]         r_refr_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest      <= POT_W'(3277);
            r_inv_tau   <= RECIP_W'(13107);
            r_steps     <= STEPS_W'(10);
            r_inv_step  <= RECIP_W'(6554);
            r_refr_time <= REFR_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REST:     r_rest      <= i_cfg_wdata;
                CFG_INV_TAU:  r_inv_tau   <= i_cfg_wdata[RECIP_W-1:0];
                CFG_STEPS:    r_steps     <= i_cfg_wdata[STEPS_W-1:0];
                CFG_INV_STEP: r_inv_step  <= i_cfg_wdata[RECIP_W-1:0];
                CFG_REFR:     r_refr_time <= i_cfg_wdata[REFR_W-1:0];
                default:      ;
            endcase
        end
    end

    // latched item
    logic                      r_cmd;
    logic [IDX_W-1:0]          r_idx;
    logic signed [POT_W-1:0]   r_cur;
    logic [SMP_W-1:0]          r_smp;
    logic signed [POT_W-1:0]   r_init;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_idx  <= i_neuron_index;
            r_cur  <= i_synaptic_current;
            r_smp  <= i_threshold_sample;
            r_init <= i_initial_potential;
        end
    end

    logic [EW-1:0] in_idx_ext;
    logic [EW-1:0] r_idx_ext;
    logic          in_range_new;
    logic          in_range;

    assign in_idx_ext   = EW'(i_neuron_index);
    assign r_idx_ext    = EW'(r_idx);
    assign in_range_new = in_idx_ext < EW'(NEURONS);
    assign in_range     = r_idx_ext < EW'(NEURONS);

    // clearing pass over the refractory counts after reset
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // neuron state memories
    logic signed [POT_W-1:0] r_pot_mem  [NEURONS];
    logic [REFR_W-1:0]       r_refr_mem [NEURONS];
    logic signed [POT_W-1:0] r_pot_q;
    logic [REFR_W-1:0]       r_refr_q;

    logic                    wr_en;
    logic signed [POT_W-1:0] fin_pot;
    logic [REFR_W-1:0]       fin_refr;
    logic                    fin_fired;

    assign wr_en = i_cmd.finish && in_range;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pot_mem[r_idx_ext[AW-1:0]] <= fin_pot;
        end
        if (i_cmd.accept && in_range_new) begin
            r_pot_q <= r_pot_mem[in_idx_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_refr_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_refr_mem[r_idx_ext[AW-1:0]] <= fin_refr;
        end
        if (i_cmd.accept && in_range_new) begin
            r_refr_q <= r_refr_mem[in_idx_ext[AW-1:0]];
        end
    end

    // substep arithmetic: leak product, increment product, saturating add
    logic signed [POT_W-1:0] r_x;
    logic [STEPS_W-1:0]      r_cnt;
    logic signed [P1W-1:0]   r_p1;
    logic signed [P2W-1:0]   r_p2;

    logic signed [DW-1:0]    diff;
    logic signed [RW-1:0]    inv_tau_s;
    logic signed [RW-1:0]    inv_step_s;
    logic signed [P1W-1:0]   n_p1;
    logic signed [LW-1:0]    leak;
    logic signed [SW-1:0]    sum;
    logic signed [P2W-1:0]   n_p2;
    logic signed [IW-1:0]    inc;
    logic signed [XW-1:0]    xsum;
    logic signed [POT_W-1:0] n_x_sat;

    assign diff       = DW'(r_rest) - DW'(r_x);
    assign inv_tau_s  = signed'({1'b0, r_inv_tau});
    assign inv_step_s = signed'({1'b0, r_inv_step});
    assign n_p1       = diff * inv_tau_s;
    assign leak       = LW'(r_p1 >>> FRAC_BITS);
    assign sum        = SW'(leak) + SW'(r_cur);
    assign n_p2       = sum * inv_step_s;
    assign inc        = IW'(r_p2 >>> FRAC_BITS);
    assign xsum       = XW'(inc) + XW'(r_x);

    always_comb begin
        // overflow when the sign bit of a 32-bit value and the bits above it disagree
        if ((&xsum[XW-1:POT_W-1]) || !(|xsum[XW-1:POT_W-1])) begin
            n_x_sat = xsum[POT_W-1:0];
        end else begin
            n_x_sat = xsum[XW-1] ? {1'b1, {(POT_W-1){1'b0}}} : {1'b0, {(POT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= (r_cmd == CMD_INIT) ? r_init : r_pot_q;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            r_x   <= n_x_sat;
            r_cnt <= r_cnt + STEPS_W'(1);
        end
        if (i_cmd.mul1) r_p1 <= n_p1;
        if (i_cmd.mul2) r_p2 <= n_p2;
    end

    // fire decision: x * 2^16 >= sample * 2^F, negative x never fires
    logic [CW-1:0] lhs;
    logic [CW-1:0] rhs;
    logic          fire_test;

    assign lhs       = {1'b0, r_x[POT_W-2:0], {SMP_W{1'b0}}};
    assign rhs       = CW'(r_smp) << FRAC_BITS;
    assign fire_test = !r_x[POT_W-1] && (lhs >= rhs);

    always_comb begin
        fin_pot   = r_x;
        fin_fired = 1'b0;
        fin_refr  = '0;
        if (!in_range) begin
            fin_pot = '0;
        end else if (r_cmd == CMD_INIT || r_refr_q == '0) begin
            fin_fired = fire_test;
            fin_refr  = fire_test ? r_refr_time : '0;
        end else begin
            fin_refr = r_refr_q - REFR_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_neuron_echo     <= r_idx;
            o_fired           <= fin_fired;
            o_potential       <= fin_pot;
            o_refractory_left <= fin_refr;
        end
    end

    assign o_stat.run_steps = (r_cmd == CMD_UPDATE) && in_range && (r_steps != '0);
    assign o_stat.last_step = ({1'b0, r_cnt} + 9'd1) == {1'b0, r_steps};
    assign o_stat.clr_last  = r_clr_addr == AW'(NEURONS - 1);

endmodule

/* design/slnu_chk.sv */
// Port-level checker of the neuron update unit, bound to the top level.
// Depends on stochastic_leaky_neuron_update_unit_assert.svh and slnu_pkg.
`include "stochastic_leaky_neuron_update_unit_assert.svh"

module slnu_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic                               o_fired,
    input logic signed [slnu_pkg::POT_W-1:0]  o_potential
);
    import slnu_pkg::*;

    logic accepted;
    assign accepted = start && !busy;

    `SLNU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accepted, busy, "item accepted but unit not busy")
    `SLNU_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, o_valid, $past(busy), "result without work")
    `SLNU_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `SLNU_ASSERT_SAME(a_fire_nonneg, i_clk, i_rst_n, o_valid && o_fired, !o_potential[POT_W-1], "negative potential fired")

endmodule

bind stochastic_leaky_neuron_update_unit slnu_chk u_slnu_chk (.*);

/* tb/tb_top.sv */
// Self-checking testbench for stochastic_leaky_neuron_update_unit.
// Tracks potentials and refractory counts per neuron and checks every result strobe.
// Depends on slnu_pkg (design/slnu_pkg.sv) and the unit itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slnu_pkg::*;

    localparam int NEURONS   = 1024;
    localparam int FRAC_BITS = 16;
    localparam logic [POT_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [POT_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct {
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [POT_W-1:0]  cur;
        logic [SMP_W-1:0]  smp;
        logic [POT_W-1:0]  init_pot;
    } t_neuron_cmd;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic              fired;
        logic [POT_W-1:0]  pot;
        logic [REFR_W-1:0] left;
    } t_neuron_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_command = CMD_UPDATE;
    logic [IDX_W-1:0]      i_neuron_index = '0;
    logic signed [POT_W-1:0] i_synaptic_current = '0;
    logic [SMP_W-1:0]      i_threshold_sample = '0;
    logic signed [POT_W-1:0] i_initial_potential = '0;
    logic                  o_valid;
    logic [IDX_W-1:0]      o_neuron_echo;
    logic                  o_fired;
    logic signed [POT_W-1:0] o_potential;
    logic [REFR_W-1:0]     o_refractory_left;

    // shadow of the neuron array and the registers
    logic [POT_W-1:0]  pot_mem [NEURONS];
    logic [REFR_W-1:0] refr_mem [NEURONS] = '{default: '0};
    bit                pot_known [NEURONS] = '{default: 1'b0};
    longint            rest_pot = 3277;
    longint            tau_recip = 13107;
    int                n_steps = 10;
    longint            step_recip = 6554;
    logic [REFR_W-1:0] refr_time = 10'd4;

    t_neuron_out outcomes [$];
    t_neuron_out want;
    int          n_errors = 0;
    int          idle_pct = 36;

    stochastic_leaky_neuron_update_unit #(
        .NEURONS   (NEURONS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_neuron_index      (i_neuron_index),
        .i_synaptic_current  (i_synaptic_current),
        .i_threshold_sample  (i_threshold_sample),
        .i_initial_potential (i_initial_potential),
        .o_valid             (o_valid),
        .o_neuron_echo       (o_neuron_echo),
        .o_fired             (o_fired),
        .o_potential         (o_potential),
        .o_refractory_left   (o_refractory_left)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic bit crosses(input longint x, input logic [SMP_W-1:0] smp);
        return (x * 65536) >= (longint'(smp) << FRAC_BITS);
    endfunction

    // Advances the shadow neuron and returns the result the unit must show.
    function automatic t_neuron_out integrate_and_fire(input t_neuron_cmd c);
        t_neuron_out       o;
        longint            x;
        longint            leak;
        longint            incr;
        int                k;
        bit                f;
        logic [REFR_W-1:0] left;
        f = 1'b0;
        if (c.cmd == CMD_INIT) begin
            x = longint'($signed(c.init_pot));
            f = crosses(x, c.smp);
            left = f ? refr_time : '0;
            pot_known[c.idx] = 1'b1;
        end else begin
            x = longint'($signed(pot_mem[c.idx]));
            for (k = 0; k < n_steps; k++) begin
                leak = ((rest_pot - x) * tau_recip) >>> FRAC_BITS;
                incr = ((leak + longint'($signed(c.cur))) * step_recip) >>> FRAC_BITS;
                x = clamp32(x + incr);
            end
            left = refr_mem[c.idx];
            if (left == '0) begin
                f = crosses(x, c.smp);
                left = f ? refr_time : '0;
            end else begin
                left = left - 1'b1;
            end
        end
        pot_mem[c.idx]  = x[POT_W-1:0];
        refr_mem[c.idx] = left;
        o.idx   = c.idx;
        o.fired = f;
        o.pot   = x[POT_W-1:0];
        o.left  = left;
        return o;
    endfunction

    function automatic t_neuron_cmd neuron_cmd(input logic cmd, input logic [IDX_W-1:0] idx,
                                               input logic [POT_W-1:0] cur,
                                               input logic [SMP_W-1:0] smp,
                                               input logic [POT_W-1:0] init_pot);
        t_neuron_cmd c;
        c.cmd = cmd;
        c.idx = idx;
        c.cur = cur;
        c.smp = smp;
        c.init_pot = init_pot;
        return c;
    endfunction

    // Q16.16 value: often near the threshold range, sometimes anywhere, zero or at the rails
    function automatic logic [POT_W-1:0] pick_q16();
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3, 4, 5: return $urandom();
            default: return 32'($urandom_range(0, 262144)) - 32'd131072;
        endcase
    endfunction

    function automatic t_neuron_cmd random_command();
        t_neuron_cmd c;
        // a few hot neurons keep refractory chains going
        if ($urandom_range(99) < 60)
            c.idx = $urandom_range(1) ? IDX_W'($urandom_range(0, 7))
                                      : IDX_W'($urandom_range(1016, 1023));
        else
            c.idx = IDX_W'($urandom());
        // never update a neuron whose potential was never loaded
        c.cmd = (!pot_known[c.idx] || $urandom_range(99) < 18) ? CMD_INIT : CMD_UPDATE;
        c.cur = pick_q16();
        c.init_pot = pick_q16();
        c.smp = ($urandom_range(3) == 0) ? SMP_W'($urandom_range(0, 255)) : SMP_W'($urandom());
        return c;
    endfunction

    task automatic send_item(input t_neuron_cmd c);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat (($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
        start               <= 1'b1;
        i_command           <= c.cmd;
        i_neuron_index      <= c.idx;
        i_synaptic_current  <= c.cur;
        i_threshold_sample  <= c.smp;
        i_initial_potential <= c.init_pot;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        outcomes.push_back(integrate_and_fire(c));
    endtask

    task automatic wait_all_reported();
        start <= 1'b0;
        while (outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= r;
        i_cfg_wdata <= d;
        @(posedge i_clk);
    endtask

    // unit must be idle; upper bits beyond a register's width are don't-care
    task automatic load_config(input logic [CFG_W-1:0] rest, input logic [CFG_W-1:0] tau,
                               input logic [CFG_W-1:0] steps, input logic [CFG_W-1:0] isub,
                               input logic [CFG_W-1:0] refr);
        put_reg(CFG_REST, rest);
        put_reg(CFG_INV_TAU, tau);
        put_reg(CFG_STEPS, steps);
        put_reg(CFG_INV_STEP, isub);
        put_reg(CFG_REFR, refr);
        i_cfg_we   <= 1'b0;
        rest_pot   = longint'($signed(rest));
        tau_recip  = longint'(tau[RECIP_W-1:0]);
        n_steps    = int'(steps[STEPS_W-1:0]);
        step_recip = longint'(isub[RECIP_W-1:0]);
        refr_time  = refr[REFR_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_random_config(input int max_steps);
        logic [CFG_W-1:0] rest;
        logic [CFG_W-1:0] tau;
        logic [CFG_W-1:0] isub;
        logic [CFG_W-1:0] refr;
        rest = $urandom_range(1) ? pick_q16() : 32'($urandom_range(0, 98304)) - 32'd16384;
        tau  = ($urandom() & 32'hFFFE_0000) |
               (($urandom_range(3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536));
        isub = ($urandom() & 32'hFFFE_0000) |
               (($urandom_range(3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536));
        refr = ($urandom() & 32'hFFFF_FC00) |
               (($urandom_range(3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12));
        load_config(rest, tau, ($urandom() & 32'hFFFF_FF00) | $urandom_range(1, max_steps),
                    isub, refr);
    endtask

    task automatic check_field(input string what, input logic [POT_W-1:0] exp_v,
                               input logic [POT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (outcomes.size() == 0) begin
                $display("%0t: result expected none actual neuron %0d", $time, o_neuron_echo);
                n_errors++;
            end else begin
                want = outcomes.pop_front();
                check_field("neuron_echo", want.idx, o_neuron_echo);
                check_field("fired", want.fired, o_fired);
                check_field("potential", want.pot, o_potential);
                check_field("refractory_left", want.left, o_refractory_left);
            end
        end
    end

    // threshold edges on init, at reset settings
    task automatic test_fire_threshold();
        idle_pct = 36;
        send_item(neuron_cmd(CMD_INIT, 10'd0, 32'hFFFF_FFFF, 16'd0, 32'd0));
        send_item(neuron_cmd(CMD_INIT, 10'd1, Q_MAX, 16'd0, Q_MIN));
        send_item(neuron_cmd(CMD_INIT, 10'd2, Q_MIN, 16'hFFFF, 32'd65535));
        send_item(neuron_cmd(CMD_INIT, 10'd3, 32'd0, 16'hFFFF, 32'd65534));
        send_item(neuron_cmd(CMD_INIT, 10'd1023, 32'h5555_5555, 16'hFFFF, Q_MAX));
        send_item(neuron_cmd(CMD_INIT, 10'd4, 32'hAAAA_AAAA, 16'h8001, 32'h0000_8000));
    endtask

    // neuron 0 fired at init: four silent updates, then a fresh decision
    task automatic test_refractory();
        int i;
        for (i = 0; i < 5; i++)
            send_item(neuron_cmd(CMD_UPDATE, 10'd0, 32'd0, 16'd0,
                                 (i % 2) ? Q_MIN : Q_MAX));
    endtask

    task automatic test_saturation();
        send_item(neuron_cmd(CMD_UPDATE, 10'd1023, Q_MAX, 16'd0, 32'd0));
        send_item(neuron_cmd(CMD_UPDATE, 10'd1, Q_MIN, 16'hFFFF, Q_MAX));
        wait_all_reported();
    endtask

    // zero substeps, reciprocals above one, refractory time at both ends
    task automatic test_register_extremes();
        load_config(Q_MIN, 32'd131071, 32'd0, 32'd131071, 32'd1023);
        send_item(neuron_cmd(CMD_UPDATE, 10'd2, 32'd12345, 16'd0, 32'd0));
        send_item(neuron_cmd(CMD_UPDATE, 10'd3, Q_MAX, 16'd0, 32'd0));
        send_item(neuron_cmd(CMD_INIT, 10'd5, 32'd0, 16'd100, 32'd100));
        wait_all_reported();
        load_config(Q_MAX, 32'd65536, 32'd1, 32'd65536, 32'd0);
        send_item(neuron_cmd(CMD_UPDATE, 10'd4, 32'd0, 16'd0, 32'd0));
        send_item(neuron_cmd(CMD_UPDATE, 10'd1, Q_MAX, 16'hFFFF, 32'd0));
        send_item(neuron_cmd(CMD_INIT, 10'd6, 32'd0, 16'd0, 32'd0));
        wait_all_reported();
    endtask

    task automatic test_random_traffic(input int phase, input int n_items);
        int i;
        case (phase)
            0: load_config(32'd3277, 32'd13107, 32'd10, 32'd6554, 32'd4);
            1: load_config(Q_MAX, 32'd65536, 32'd1, 32'd65536, 32'd0);
            2: load_config(Q_MIN, 32'd0, 32'd3, 32'd1, 32'd1023);
            default: load_random_config(16);
        endcase
        idle_pct = (phase < 2) ? 36 : (phase < 4) ? 53 : 0;
        for (i = 0; i < n_items; i++) begin
            send_item(random_command());
            if (phase == 1 && i == n_items / 2)
                wait_all_reported();
        end
        wait_all_reported();
    endtask

    // full substep count, kept short since each update is slow
    task automatic test_long_integration();
        int i;
        load_random_config(1);
        load_config(pick_q16(), $urandom_range(0, 65536), 32'd255, $urandom_range(0, 8192),
                    $urandom_range(0, 3));
        idle_pct = 0;
        for (i = 0; i < 12; i++)
            send_item(random_command());
        wait_all_reported();
    endtask

    initial begin
        int p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // refractory clearing pass after reset
        while (busy !== 1'b0) @(posedge i_clk);
        test_fire_threshold();
        test_refractory();
        test_saturation();
        test_register_extremes();
        for (p = 0; p < 6; p++)
            test_random_traffic(p, 305);
        test_long_integration();
        wait_all_reported();
        repeat (8 + 3 * n_steps) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/slnu_pkg.sv
design/slnu_ctrl.sv
design/slnu_dp.sv
design/stochastic_leaky_neuron_update_unit.sv
design/slnu_chk.sv
tb/tb_top.sv
